FILE: rtl/core/gdr_pkg.sv
// shared types and constants of the grid dda wall raycaster
package gdr_pkg;

  localparam int MapWDef = 64;
  localparam int MapHDef = 64;

  localparam int NumW    = 33;   // divider dividend and quotient width
  localparam int DenW    = 31;   // divider divisor width
  localparam int SdW     = 44;   // side distance accumulators
  localparam int CfgIdxW = 4;
  localparam int CfgDatW = 22;

  localparam logic [30:0] DistMax = 31'h7FFF_FFFF;
  localparam logic signed [31:0] DirLim = 32'sd262144;

  typedef enum logic {
    REQ_MAP_WRITE = 1'b0,
    REQ_CAST      = 1'b1
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POS_X   = 4'd0,
    CFG_POS_Y   = 4'd1,
    CFG_DIR_X   = 4'd2,
    CFG_DIR_Y   = 4'd3,
    CFG_PLANE_X = 4'd4,
    CFG_PLANE_Y = 4'd5,
    CFG_WIDTH   = 4'd6,
    CFG_HEIGHT  = 4'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV_U, ST_MUL, ST_DIR, ST_DIV_DX, ST_DIV_DY, ST_SIDE,
    ST_STEP, ST_CHK, ST_DIST, ST_DIV_RAW, ST_TEX, ST_OUT
  } st_e;

  typedef struct packed {
    logic       req_type;
    logic [5:0] tile_x;
    logic [5:0] tile_y;
    logic       tile_is_wall;
    logic [9:0] column;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         out_column;
    logic               hit;
    logic               hit_side;
    logic [10:0]        span_top;
    logic [10:0]        span_height;
    logic [30:0]        wall_distance;
    logic [5:0]         hit_tile_x;
    logic [5:0]         hit_tile_y;
    logic [15:0]        tex_u;
    logic signed [19:0] ray_dir_x;
    logic signed [19:0] ray_dir_y;
  } out_item_t;

  // classified item held in the queue between front and back
  typedef struct packed {
    req_e       kind;
    logic       wr_ok;
    logic [5:0] tile_x;
    logic [5:0] tile_y;
    logic       wall;
    logic [9:0] column;
  } q_item_t;

  typedef struct packed {
    logic [21:0]        pos_x;
    logic [21:0]        pos_y;
    logic signed [18:0] dir_x;
    logic signed [18:0] dir_y;
    logic signed [18:0] plane_x;
    logic signed [18:0] plane_y;
    logic [10:0]        width;
    logic [10:0]        height;
  } cam_t;

endpackage

FILE: rtl/core/gdr_front.sv
// front part: accepts items, classifies them and queues them for the back part
module gdr_front #(
  parameter int MAP_W = gdr_pkg::MapWDef,
  parameter int MAP_H = gdr_pkg::MapHDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  gdr_pkg::in_item_t in_data_i,
  input  logic              clr_busy_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output gdr_pkg::q_item_t  q_data_o
);
  import gdr_pkg::*;

  q_item_t    fifo_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  q_item_t    cls;

  // classify the incoming beat
  always_comb begin
    cls.kind   = req_e'(in_data_i.req_type);
    cls.wr_ok  = (32'(in_data_i.tile_x) < MAP_W) && (32'(in_data_i.tile_y) < MAP_H);
    cls.tile_x = in_data_i.tile_x;
    cls.tile_y = in_data_i.tile_y;
    cls.wall   = in_data_i.tile_is_wall;
    cls.column = in_data_i.column;
  end

  assign in_stall_o = (cnt_q == 2'd2) || clr_busy_i;
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_data_o   = fifo_q[rptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: rtl/core/gdr_div.sv
// restoring divider, one quotient bit per cycle
module gdr_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [gdr_pkg::NumW-1:0] num_i,
  input  logic [gdr_pkg::DenW-1:0] den_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic [gdr_pkg::NumW-1:0] quo_o
);
  import gdr_pkg::*;

  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q;
  logic [DenW-1:0] den_q, rem_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DenW:0]   sh;
  logic            ge;

  // one trial subtraction
  always_comb begin
    sh = {rem_q, num_q[NumW-1]};
    ge = (sh >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? DenW'(sh - {1'b0, den_q}) : sh[DenW-1:0];
      num_q <= {num_q[NumW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

FILE: rtl/core/gdr_back.sv
// back part: map store, ray setup, dda walk, projection and result register
module gdr_back #(
  parameter int MAP_W = gdr_pkg::MapWDef,
  parameter int MAP_H = gdr_pkg::MapHDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gdr_pkg::cam_t      cam_i,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  gdr_pkg::q_item_t   q_data_i,
  output logic               clr_busy_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output gdr_pkg::out_item_t out_data_o
);
  import gdr_pkg::*;

  localparam int Depth = MAP_W * MAP_H;
  localparam int AW    = $clog2(Depth);
  localparam int XB    = ($clog2(MAP_W) > 6) ? $clog2(MAP_W) : 6;
  localparam int YB    = ($clog2(MAP_H) > 6) ? $clog2(MAP_H) : 6;
  localparam int CW    = ((XB > YB) ? XB : YB) + 2;
  localparam logic signed [CW-1:0] MwS = CW'(MAP_W);
  localparam logic signed [CW-1:0] MhS = CW'(MAP_H);

  st_e state_q, state_d;

  // map store and clearing pass
  logic          mem_q [Depth];
  logic          rd_q;
  logic [AW-1:0] clr_cnt_q, waddr, raddr;
  logic          clr_busy_q, we, wdata;

  // ray datapath registers
  logic [9:0]             col_q;
  logic signed [27:0]     u_q;
  logic signed [46:0]     px_q, py_q;
  logic signed [19:0]     rdx_q, rdy_q, rdx_d, rdy_d;
  logic [30:0]            ddx_q, ddy_q, dd_new;
  logic [SdW-1:0]         sdx_q, sdy_q, nsdx, nsdy, dsel;
  logic signed [CW-1:0]   cx_q, cy_q, ncx, ncy;
  logic                   side_q, hit_q, nside, outside;
  logic [30:0]            dist_q, dist_d;
  logic [NumW-1:0]        raw_q;
  logic [15:0]            tex_q;
  logic signed [31:0]     sx, sy;
  logic [19:0]            ay;
  logic [16:0]            frx, fry;
  logic signed [51:0]     tprod;
  logic                   ld_out, pop;
  out_item_t              out_q, out_d;
  logic [10:0]            h;

  // divider hookup
  logic            div_start, div_busy, div_done;
  logic [NumW-1:0] div_num, div_quo;
  logic [DenW-1:0] div_den;

  gdr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign h = cam_i.height;

  // ray direction with saturation
  always_comb begin
    sx = 32'(cam_i.dir_x) + 32'(px_q >>> 16);
    sy = 32'(cam_i.dir_y) + 32'(py_q >>> 16);
    rdx_d = (sx > DirLim) ? 20'sd262144 : (sx < -DirLim) ? -20'sd262144 : 20'(sx);
    rdy_d = (sy > DirLim) ? 20'sd262144 : (sy < -DirLim) ? -20'sd262144 : 20'(sy);
    ay = rdy_q[19] ? 20'(-rdy_q) : rdy_q;
  end

  // dda step candidate and position check
  always_comb begin
    if (sdx_q < sdy_q) begin
      nsdx  = sdx_q + SdW'(ddx_q);
      nsdy  = sdy_q;
      ncx   = rdx_q[19] ? cx_q - CW'(1) : cx_q + CW'(1);
      ncy   = cy_q;
      nside = 1'b0;
    end else begin
      nsdx  = sdx_q;
      nsdy  = sdy_q + SdW'(ddy_q);
      ncx   = cx_q;
      ncy   = rdy_q[19] ? cy_q - CW'(1) : cy_q + CW'(1);
      nside = 1'b1;
    end
    outside = (cx_q < 0) || (cx_q >= MwS) || (cy_q < 0) || (cy_q >= MhS);
    raddr   = AW'(AW'(ncy) * AW'(MAP_H > 0 ? MAP_W : 1) + AW'(ncx));
  end

  // side distances at entry and projection inputs
  always_comb begin
    frx    = rdx_q[19] ? {1'b0, cam_i.pos_x[15:0]} : 17'd65536 - {1'b0, cam_i.pos_x[15:0]};
    fry    = rdy_q[19] ? {1'b0, cam_i.pos_y[15:0]} : 17'd65536 - {1'b0, cam_i.pos_y[15:0]};
    dsel   = side_q ? sdy_q - SdW'(ddy_q) : sdx_q - SdW'(ddx_q);
    dist_d = (dsel > SdW'(DistMax)) ? DistMax : dsel[30:0];
    tprod  = 52'($signed({1'b0, dist_q})) * 52'(side_q ? rdx_q : rdy_q);
    dd_new = (div_quo > NumW'(DistMax)) ? DistMax : div_quo[30:0];
  end

  // next state and control
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    pop       = 1'b0;
    ld_out    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i && !clr_busy_q) begin
          pop = 1'b1;
          if (q_data_i.kind == REQ_CAST) begin
            div_start = 1'b1;
            div_num   = NumW'({q_data_i.column, 17'd0});
            div_den   = (cam_i.width == 11'd0) ? DenW'(1) : DenW'(cam_i.width);
            state_d   = ST_DIV_U;
          end
        end
      end
      ST_DIV_U:  if (div_done) state_d = ST_MUL;
      ST_MUL:    state_d = ST_DIR;
      ST_DIR: begin
        div_start = 1'b1;
        div_num   = NumW'(64'h1_0000_0000);
        div_den   = DenW'(rdx_d[19] ? 20'(-rdx_d) : rdx_d);
        state_d   = ST_DIV_DX;
      end
      ST_DIV_DX: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num   = NumW'(64'h1_0000_0000);
          div_den   = DenW'(ay);
          state_d   = ST_DIV_DY;
        end
      end
      ST_DIV_DY: if (div_done) state_d = ST_SIDE;
      ST_SIDE:   state_d = ST_STEP;
      ST_STEP:   state_d = ST_CHK;
      ST_CHK: begin
        if (outside)   state_d = ST_OUT;
        else if (rd_q) state_d = ST_DIST;
        else           state_d = ST_STEP;
      end
      ST_DIST: begin
        div_start = 1'b1;
        div_num   = NumW'({h, 16'd0});
        div_den   = dist_d;
        state_d   = ST_DIV_RAW;
      end
      ST_DIV_RAW: if (div_done) state_d = ST_TEX;
      ST_TEX:     state_d = ST_OUT;
      ST_OUT: begin
        if (!out_valid_o || !out_stall_i) begin
          ld_out  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign q_ready_o = (state_q == ST_IDLE) && !clr_busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE:   col_q <= q_data_i.column;
      ST_DIV_U:  u_q <= $signed({1'b0, div_quo[26:0]}) - 28'sd65536;
      ST_MUL: begin
        px_q <= 47'(cam_i.plane_x) * 47'(u_q);
        py_q <= 47'(cam_i.plane_y) * 47'(u_q);
      end
      ST_DIR: begin
        rdx_q <= rdx_d;
        rdy_q <= rdy_d;
      end
      ST_DIV_DX: ddx_q <= (rdx_q == 20'sd0) ? DistMax : dd_new;
      ST_DIV_DY: ddy_q <= (rdy_q == 20'sd0) ? DistMax : dd_new;
      ST_SIDE: begin
        sdx_q  <= SdW'((48'(frx) * 48'(ddx_q)) >> 16);
        sdy_q  <= SdW'((48'(fry) * 48'(ddy_q)) >> 16);
        cx_q   <= CW'(cam_i.pos_x[21:16]);
        cy_q   <= CW'(cam_i.pos_y[21:16]);
        side_q <= 1'b0;
        hit_q  <= 1'b0;
      end
      ST_STEP: begin
        sdx_q  <= nsdx;
        sdy_q  <= nsdy;
        cx_q   <= ncx;
        cy_q   <= ncy;
        side_q <= nside;
      end
      ST_CHK:     hit_q <= !outside && rd_q;
      ST_DIST:    dist_q <= dist_d;
      ST_DIV_RAW: raw_q <= (dist_q == 31'd0) ? NumW'(h) : div_quo;
      ST_TEX:     tex_q <= (side_q ? cam_i.pos_x[15:0] : cam_i.pos_y[15:0]) + tprod[31:16];
      ST_OUT:     ;
      default:    ;
    endcase
  end

  // result assembly
  always_comb begin
    out_d            = '0;
    out_d.out_column = col_q;
    out_d.hit        = hit_q;
    out_d.hit_side   = side_q;
    if (hit_q) begin
      out_d.span_height   = (raw_q > NumW'(h)) ? h : raw_q[10:0];
      out_d.span_top      = (raw_q >= NumW'(h)) ? 11'd0 : (h - raw_q[10:0]) >> 1;
      out_d.wall_distance = dist_q;
      out_d.hit_tile_x    = cx_q[5:0];
      out_d.hit_tile_y    = cy_q[5:0];
      out_d.tex_u         = tex_q;
      out_d.ray_dir_x     = rdx_q;
      out_d.ray_dir_y     = rdy_q;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (ld_out) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)          out_valid_o <= 1'b0;
    else if (ld_out)      out_valid_o <= 1'b1;
    else if (!out_stall_i) out_valid_o <= 1'b0;
  end

  assign out_data_o = out_q;

  // map write port: clearing pass or tile write
  always_comb begin
    we    = clr_busy_q || (pop && q_data_i.kind == REQ_MAP_WRITE && q_data_i.wr_ok);
    waddr = clr_busy_q ? clr_cnt_q
                       : AW'(AW'(q_data_i.tile_y) * AW'(MAP_W) + AW'(q_data_i.tile_x));
    wdata = !clr_busy_q && q_data_i.wall;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rd_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == AW'(Depth - 1)) clr_busy_q <= 1'b0;
    end
  end

  assign clr_busy_o = clr_busy_q;

  // checks
  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !pop) else $error("item taken during map clear");
  a_step_then_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_STEP |=> state_q == ST_CHK) else $error("dda step not followed by check");
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_out |-> (!out_valid_o || !out_stall_i)) else $error("result overwritten");

endmodule

FILE: rtl/core/grid_dda_wall_raycaster.sv
// Column ray caster over a MAP_W x MAP_H grid of wall bits; positions are Q6.16.
// A map write is done by the back end as it takes the item from the queue. A cast
// runs up to four serial divisions in one shared divider (column scale, two
// inverse ray slopes, projected height), and each DDA step is a step state
// followed by a check state because each step does one registered map read; a
// cast takes at most MAP_W + MAP_H + 2 steps. A two entry queue separates the
// input side from the back end, and a result register lets the next item start
// while a finished result waits. After reset the map is cleared one tile per
// cycle until all MAP_W * MAP_H tiles are written, during which input is
// stalled; configuration writes are taken at any time and must only happen idle.
module grid_dda_wall_raycaster #(
  parameter int MAP_W = gdr_pkg::MapWDef,
  parameter int MAP_H = gdr_pkg::MapHDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  gdr_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output gdr_pkg::out_item_t          out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [gdr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [gdr_pkg::CfgDatW-1:0] cfg_data_i
);
  import gdr_pkg::*;

  cam_t    cam_q;
  q_item_t q_data;
  logic    q_valid, q_ready, clr_busy;

  assign cfg_ready_o = 1'b1;

  // camera and screen registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_q.pos_x   <= 22'd2097152;
      cam_q.pos_y   <= 22'd2097152;
      cam_q.dir_x   <= 19'sd65536;
      cam_q.dir_y   <= 19'sd0;
      cam_q.plane_x <= 19'sd0;
      cam_q.plane_y <= 19'sd43690;
      cam_q.width   <= 11'd320;
      cam_q.height  <= 11'd200;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_POS_X:   cam_q.pos_x   <= cfg_data_i;
        CFG_POS_Y:   cam_q.pos_y   <= cfg_data_i;
        CFG_DIR_X:   cam_q.dir_x   <= cfg_data_i[18:0];
        CFG_DIR_Y:   cam_q.dir_y   <= cfg_data_i[18:0];
        CFG_PLANE_X: cam_q.plane_x <= cfg_data_i[18:0];
        CFG_PLANE_Y: cam_q.plane_y <= cfg_data_i[18:0];
        CFG_WIDTH:   cam_q.width   <= cfg_data_i[10:0];
        CFG_HEIGHT:  cam_q.height  <= cfg_data_i[10:0];
        default:     ;
      endcase
    end
  end

  gdr_front #(.MAP_W(MAP_W), .MAP_H(MAP_H)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .clr_busy_i (clr_busy),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_data_o   (q_data)
  );

  gdr_back #(.MAP_W(MAP_W), .MAP_H(MAP_H)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cam_i       (cam_q),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_data_i    (q_data),
    .clr_busy_o  (clr_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
